// ===== hdl/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// Clipped sprite blitter package
// Shared types, register indexes and defaults for the sprite blitter.
// ----------------------------------------------------------------------------
package csb_pkg;

    // Default parameter values.
    localparam int DEF_MAX_SPRITE_DIM = 256;
    localparam int DEF_ADDR_BITS      = 20;

    // Fixed field widths.
    localparam int DIM_W      = 9;
    localparam int POS_W      = 12;
    localparam int SCR_POS_W  = POS_W + 1;
    localparam int PIXEL_W    = 8;
    localparam int SCREEN_W   = 11;
    localparam int OUT_ADDR_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // Register reset values.
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 11'd200;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Input word kinds.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_PIXEL = 1'b1
    } cmd_t;

    // One classified pixel, as handed from front to back.
    typedef struct packed {
        logic [SCR_POS_W-1:0] sx;
        logic [SCR_POS_W-1:0] sy;
        logic [PIXEL_W-1:0]   pixel;
        logic                 last;
    } pix_entry_t;

endpackage

// ===== hdl/csb_front.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter front end
// Accepts input words, latches sprite geometry, walks the pixel counters and
// pushes each counted pixel with its screen coordinates into the queue.
// ----------------------------------------------------------------------------
module csb_front
    import csb_pkg::*;
#(
    parameter int MAX_SPRITE_DIM = DEF_MAX_SPRITE_DIM
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [0:0]         command,
    input  logic [DIM_W-1:0]   sprite_cols,
    input  logic [DIM_W-1:0]   sprite_rows,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [PIXEL_W-1:0] pixel_in,
    input  logic               q_full,
    output logic               q_push,
    output pix_entry_t         q_entry
);

    // Width wide enough to compare a dimension against the size limit.
    localparam int LIM_W = ($clog2(MAX_SPRITE_DIM + 1) > DIM_W) ?
                           $clog2(MAX_SPRITE_DIM + 1) : DIM_W;
    localparam logic [LIM_W-1:0] DIM_LIMIT = LIM_W'(MAX_SPRITE_DIM);

    logic [DIM_W-1:0] cur_width_reg,  cur_width_next;
    logic [DIM_W-1:0] cur_height_reg, cur_height_next;
    logic [POS_W-1:0] origin_x_reg,   origin_x_next;
    logic [POS_W-1:0] origin_y_reg,   origin_y_next;
    logic [DIM_W-1:0] col_count_reg,  col_count_next;
    logic [DIM_W-1:0] row_count_reg,  row_count_next;

    logic             accept;
    logic             in_sprite;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;

    // Saturate an oversized dimension to the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [LIM_W-1:0] d_ext;
        d_ext = LIM_W'(d);
        if (d_ext > DIM_LIMIT)
            clamp_dim = DIM_W'(DIM_LIMIT);
        else
            clamp_dim = d;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // A pixel counts only while the sprite still has pixels left.
    assign in_sprite = (cur_width_reg != '0) && (row_count_reg < cur_height_reg);
    assign q_push    = accept && (command == CMD_PIXEL) && in_sprite;

    assign col_inc = {1'b0, col_count_reg} + {{DIM_W{1'b0}}, 1'b1};
    assign row_inc = {1'b0, row_count_reg} + {{DIM_W{1'b0}}, 1'b1};

    // Screen coordinates of the current pixel, in two's complement.
    always_comb
    begin
        q_entry.sx    = {origin_x_reg[POS_W-1], origin_x_reg}
                        + SCR_POS_W'(col_count_reg);
        q_entry.sy    = {origin_y_reg[POS_W-1], origin_y_reg}
                        + SCR_POS_W'(row_count_reg);
        q_entry.pixel = pixel_in;
        q_entry.last  = (row_inc == {1'b0, cur_height_reg})
                        && (col_inc == {1'b0, cur_width_reg});
    end

    // Geometry latch and raster counters.
    always_comb
    begin
        cur_width_next  = cur_width_reg;
        cur_height_next = cur_height_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        col_count_next  = col_count_reg;
        row_count_next  = row_count_reg;
        if (accept && (command == CMD_START))
        begin
            cur_width_next  = clamp_dim(sprite_cols);
            cur_height_next = clamp_dim(sprite_rows);
            origin_x_next   = pos_x;
            origin_y_next   = pos_y;
            col_count_next  = '0;
            row_count_next  = '0;
        end
        else if (q_push)
        begin
            if (col_inc >= {1'b0, cur_width_reg})
            begin
                col_count_next = '0;
                row_count_next = row_inc[DIM_W-1:0];
            end
            else
            begin
                col_count_next = col_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_width_reg  <= '0;
            cur_height_reg <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
        end
        else
        begin
            cur_width_reg  <= cur_width_next;
            cur_height_reg <= cur_height_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            col_count_reg  <= col_count_next;
            row_count_reg  <= row_count_next;
        end
    end

endmodule

// ===== hdl/csb_queue.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter pixel queue
// Short first-in first-out buffer that decouples the front end from the
// clip and address back end.
// ----------------------------------------------------------------------------
module csb_queue
    import csb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pix_entry_t push_entry,
    output logic       full,
    output logic       not_empty,
    input  logic       pop,
    output pix_entry_t pop_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    pix_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hdl/csb_back.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter back end
// Clips each queued pixel against the screen, disables writes of transparent
// pixels and forms the frame buffer address in a two-stage stallable pipeline.
// ----------------------------------------------------------------------------
module csb_back
    import csb_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  pix_entry_t            q_entry,
    output logic                  q_pop,
    input  logic [SCREEN_W-1:0]   screen_width,
    input  logic [SCREEN_W-1:0]   screen_height,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  write_enable,
    output logic [OUT_ADDR_W-1:0] write_address,
    output logic [PIXEL_W-1:0]    write_pixel,
    output logic                  sprite_done
);

    // Row times stride plus column, before the wrap.
    localparam int PROD_W = 2 * SCREEN_W + 1;
    localparam logic [PROD_W-1:0] ADDR_MASK = (ADDR_BITS >= PROD_W) ? {PROD_W{1'b1}} :
                                             PROD_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Clip stage.
    logic                a_valid_reg;
    logic                a_vis_reg;
    logic [SCREEN_W-1:0] a_sx_reg;
    logic [SCREEN_W-1:0] a_sy_reg;
    logic [PIXEL_W-1:0]  a_pixel_reg;
    logic                a_last_reg;

    // Output stage.
    logic                  b_valid_reg;
    logic                  b_we_reg;
    logic [OUT_ADDR_W-1:0] b_addr_reg;
    logic [PIXEL_W-1:0]    b_pixel_reg;
    logic                  b_last_reg;

    logic              b_ready;
    logic              a_adv;
    logic              visible;
    logic [PROD_W-1:0] addr_full;
    logic [PROD_W-1:0] addr_wrap;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_adv   = !a_valid_reg || b_ready;
    assign q_pop   = q_valid && a_adv;

    // Opaque and inside the screen on both axes.
    assign visible = (q_entry.pixel != '0)
                     && !q_entry.sx[SCR_POS_W-1]
                     && (q_entry.sx[POS_W-1:0] < POS_W'(screen_width))
                     && !q_entry.sy[SCR_POS_W-1]
                     && (q_entry.sy[POS_W-1:0] < POS_W'(screen_height));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_adv)
            a_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_vis_reg   <= visible;
            a_sx_reg    <= q_entry.sx[SCREEN_W-1:0];
            a_sy_reg    <= q_entry.sy[SCREEN_W-1:0];
            a_pixel_reg <= q_entry.pixel;
            a_last_reg  <= q_entry.last;
        end
    end

    // Frame buffer address, wrapped to the address space.
    assign addr_full = PROD_W'(a_sy_reg) * PROD_W'(screen_width) + PROD_W'(a_sx_reg);
    assign addr_wrap = addr_full & ADDR_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_ready)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_we_reg    <= a_vis_reg;
            b_addr_reg  <= a_vis_reg ? addr_wrap[OUT_ADDR_W-1:0] : '0;
            b_pixel_reg <= a_vis_reg ? a_pixel_reg : '0;
            b_last_reg  <= a_last_reg;
        end
    end

    assign out_valid     = b_valid_reg;
    assign write_enable  = b_we_reg;
    assign write_address = b_addr_reg;
    assign write_pixel   = b_pixel_reg;
    assign sprite_done   = b_last_reg;

`ifndef SYNTH
    // An enabled write never carries the transparent color.
    a_we_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |-> (write_pixel != '0))
        else $error("enabled write with transparent pixel");

    // A disabled write carries a zero address and pixel.
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> ((write_address == '0) && (write_pixel == '0)))
        else $error("disabled write with nonzero payload");

    // A clip stage word held by a stall is not lost.
    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_adv) |=> a_valid_reg)
        else $error("clip stage word dropped while stalled");

    // The queue is popped only when the clip stage can take the word.
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!a_valid_reg || !b_valid_reg || out_ready))
        else $error("queue popped into a full pipeline");
`endif

endmodule

// ===== hdl/clipped_transparent_sprite_blit.sv =====
// Path: an accepted pixel word is written into the queue, then registered in
// the clip stage and in the output register, which shows its write request.
// Throughput: one word per cycle if out_ready is high; queue, clip stage and
// output register all advance each cycle; the address multiply is one stage.
// Reset: counters and geometry clear to zero, screen size resets to 320x200;
// there is no clearing pass, words are accepted right after reset.
// ----------------------------------------------------------------------------
// Clipped transparent sprite blitter
// Turns a stream of sprite start and pixel words into frame buffer writes,
// clipped to the screen and with color zero left unwritten.
// ----------------------------------------------------------------------------
module clipped_transparent_sprite_blit
    import csb_pkg::*;
#(
    parameter int MAX_SPRITE_DIM = DEF_MAX_SPRITE_DIM,
    parameter int ADDR_BITS      = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SCREEN_W-1:0]   cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [0:0]            command,
    input  logic [DIM_W-1:0]      sprite_cols,
    input  logic [DIM_W-1:0]      sprite_rows,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [PIXEL_W-1:0]    pixel_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  write_enable,
    output logic [OUT_ADDR_W-1:0] write_address,
    output logic [PIXEL_W-1:0]    write_pixel,
    output logic                  sprite_done
);

    logic [SCREEN_W-1:0] screen_width_reg,  screen_width_next;
    logic [SCREEN_W-1:0] screen_height_reg, screen_height_next;

    logic       q_full;
    logic       q_push;
    logic       q_not_empty;
    logic       q_pop;
    pix_entry_t push_entry;
    pix_entry_t pop_entry;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                REG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
        end
    end

    // Front end: word intake and raster counters.
    csb_front #(
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .sprite_cols (sprite_cols),
        .sprite_rows (sprite_rows),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pixel_in    (pixel_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    // Decoupling queue.
    csb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    // Back end: clip, address and output register.
    csb_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .q_entry       (pop_entry),
        .q_pop         (q_pop),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_enable  (write_enable),
        .write_address (write_address),
        .write_pixel   (write_pixel),
        .sprite_done   (sprite_done)
    );

endmodule
